>>> src/gmi_pkg.sv
// gmi_pkg: shared types, codes, constants and the exp table generator
// for the gaussian midpoint integrator; no dependencies
package gmi_pkg;

    localparam int VALUE_W        = 32;
    localparam int COUNT_W        = 27;
    localparam int DEN_W          = COUNT_W + 1;
    localparam int SUM_W          = 64;
    localparam int FRACTION_BITS_DEF     = 28;
    localparam int EXP_TABLE_ENTRIES_DEF = 64;
    localparam int QUEUE_DEPTH    = 2;
    localparam int DIV_STEPS      = SUM_W;

    localparam logic [31:0] LOG2E_Q31 = 32'd3098164009;
    localparam logic [63:0] LN2_Q32   = 64'd2977044472;

    localparam logic [VALUE_W-1:0] RESET_LOWER = 32'hC000_0000;
    localparam logic [VALUE_W-1:0] RESET_UPPER = 32'h4000_0000;
    localparam logic [COUNT_W-1:0] RESET_COUNT = 27'd40000000;

    typedef enum logic [1:0] {
        CFG_LOWER = 2'd0,
        CFG_UPPER = 2'd1,
        CFG_COUNT = 2'd2
    } t_cfg_reg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV_OFS,
        ST_DIV_STEP,
        ST_RUN,
        ST_DRAIN,
        ST_DIV_SUM,
        ST_MUL,
        ST_DIV_FRAC,
        ST_ROUND,
        ST_FIN
    } t_back_state;

    typedef struct packed {
        logic [VALUE_W-1:0] lower;
        logic [VALUE_W-1:0] upper;
        logic [COUNT_W-1:0] count;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_cmd_slot;

    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] dividend;
        logic [DEN_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [SUM_W-1:0] quo;
        logic [DEN_W-1:0] rem;
    } t_div_rsp;

    typedef struct packed {
        logic               valid;
        logic [VALUE_W-1:0] x;
    } t_smp_req;

    typedef struct packed {
        logic        valid;
        logic        busy;
        logic [31:0] value;
    } t_smp_rsp;

    // 2^-z for a q32 fraction z, q31 result, by a 25 term series of exp(-z ln2)
    function automatic logic [31:0] pow2_neg_q31(logic [63:0] z);
        logic [127:0] zu;
        logic [63:0]  u;
        logic [63:0]  term;
        logic [63:0]  pos;
        logic [63:0]  neg;
        logic [63:0]  diff;
        int           k;
        zu   = 128'(z) * 128'(LN2_Q32);
        u    = zu[95:32];
        term = 64'd1 << 32;
        pos  = term;
        neg  = 64'd0;
        for (k = 1; k <= 24; k++) begin
            term = ((term * u) >> 32) / 64'(k);
            if (k % 2 == 1) begin
                neg = neg + term;
            end else begin
                pos = pos + term;
            end
        end
        diff = ((pos - neg) + 64'd1) >> 1;
        return diff[31:0];
    endfunction

endpackage

>>> src/gmi_if.sv
// gmi_if: handshake channels of the integrator, request and result words
// depends on gmi_pkg
interface gmi_go_if;
    logic valid;
    logic ready;
    logic go;
    modport source (output valid, output go, input ready);
    modport sink   (input valid, input go, output ready);
endinterface

interface gmi_result_if;
    logic                             valid;
    logic                             ready;
    logic signed [gmi_pkg::VALUE_W-1:0] integral_value;
    modport source (output valid, output integral_value, input ready);
    modport sink   (input valid, input integral_value, output ready);
endinterface

>>> src/gmi_queue.sv
// gmi_queue: short command queue between front and back
// depends on gmi_pkg
module gmi_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  gmi_pkg::t_cmd_slot i_push,
    output logic               o_full,
    input  logic               i_pop,
    output gmi_pkg::t_cmd_slot o_head
);
    localparam int PTR_W = (gmi_pkg::QUEUE_DEPTH > 1) ? $clog2(gmi_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(gmi_pkg::QUEUE_DEPTH + 1);

    gmi_pkg::t_cmd r_mem [gmi_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic w_push;
    logic w_pop;

    assign o_full       = (r_cnt == CNT_W'(gmi_pkg::QUEUE_DEPTH));
    assign o_head.valid = (r_cnt != '0);
    assign o_head.cmd   = r_mem[r_rd];
    assign w_push       = i_push.valid && !o_full;
    assign w_pop        = i_pop && o_head.valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_push.cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == PTR_W'(gmi_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (w_pop) begin
                r_rd <= (r_rd == PTR_W'(gmi_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            r_cnt <= r_cnt + CNT_W'(w_push) - CNT_W'(w_pop);
        end
    end
endmodule

>>> src/gmi_front.sv
// gmi_front: configuration registers, request intake and classification
// depends on gmi_pkg and gmi_if
module gmi_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [1:0]                 i_cfg_idx,
    input  logic [gmi_pkg::VALUE_W-1:0] i_cfg_data,
    gmi_go_if.sink                     i_go,
    input  logic                       i_q_full,
    output gmi_pkg::t_cmd_slot         o_push
);
    logic [gmi_pkg::VALUE_W-1:0] r_lower;
    logic [gmi_pkg::VALUE_W-1:0] r_upper;
    logic [gmi_pkg::COUNT_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lower <= gmi_pkg::RESET_LOWER;
            r_upper <= gmi_pkg::RESET_UPPER;
            r_count <= gmi_pkg::RESET_COUNT;
        end else if (i_cfg_we) begin
            unique case (gmi_pkg::t_cfg_reg'(i_cfg_idx))
                gmi_pkg::CFG_LOWER: r_lower <= i_cfg_data;
                gmi_pkg::CFG_UPPER: r_upper <= i_cfg_data;
                gmi_pkg::CFG_COUNT: r_count <= i_cfg_data[gmi_pkg::COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // idle requests are taken and dropped
    assign i_go.ready       = !i_q_full;
    assign o_push.valid     = i_go.valid && i_go.go && !i_q_full;
    assign o_push.cmd.lower = r_lower;
    assign o_push.cmd.upper = r_upper;
    assign o_push.cmd.count = r_count;
endmodule

>>> src/gmi_div.sv
// gmi_div: restoring divider, one quotient bit per cycle
// depends on gmi_pkg
module gmi_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  gmi_pkg::t_div_req i_req,
    output gmi_pkg::t_div_rsp o_rsp
);
    localparam int CNT_W = $clog2(gmi_pkg::DIV_STEPS);
    localparam int DW    = gmi_pkg::DEN_W;

    logic                      r_busy;
    logic                      r_done;
    logic [CNT_W-1:0]          r_cnt;
    logic [DW-1:0]             r_rem;
    logic [DW-1:0]             r_dvs;
    logic [gmi_pkg::SUM_W-1:0] r_quo;
    logic [DW:0]               w_sh;
    logic [DW:0]               w_diff;
    logic                      w_fit;

    assign w_sh   = {r_rem, r_quo[gmi_pkg::SUM_W-1]};
    assign w_diff = w_sh - {1'b0, r_dvs};
    assign w_fit  = (w_sh >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[gmi_pkg::SUM_W-2:0], w_fit};
            r_rem <= w_fit ? w_diff[DW-1:0] : w_sh[DW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(gmi_pkg::DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;
    assign o_rsp.rem  = r_rem;
endmodule

>>> src/gmi_eval.sv
// gmi_eval: eight stage pipeline for exp(-x*x) as 2^(-x*x*log2e)
// depends on gmi_pkg
module gmi_eval #(
    parameter int FRACTION_BITS     = gmi_pkg::FRACTION_BITS_DEF,
    parameter int EXP_TABLE_ENTRIES = gmi_pkg::EXP_TABLE_ENTRIES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  gmi_pkg::t_smp_req i_req,
    output gmi_pkg::t_smp_rsp o_rsp
);
    localparam int SQ_SHIFT = 2 * FRACTION_BITS - 32;
    localparam int IDX_W    = $clog2(EXP_TABLE_ENTRIES + 1);
    localparam int POS_W    = 32 + IDX_W;
    localparam logic [63:0] BIG_X2 = 64'd22 << 32;

    logic [31:0] w_tab [EXP_TABLE_ENTRIES + 1];

    for (genvar gi = 0; gi <= EXP_TABLE_ENTRIES; gi++) begin : g_tab
        localparam logic [63:0] Z     = (64'(gi) << 32) / EXP_TABLE_ENTRIES;
        localparam logic [31:0] TAB_V = gmi_pkg::pow2_neg_q31(Z);
        assign w_tab[gi] = TAB_V;
    end

    logic [8:1]       r_v;
    logic [31:0]      r1_ax;
    logic [63:0]      r2_x2;
    logic             r3_zero;
    logic [36:0]      r3_pa;
    logic [63:0]      r3_pb;
    logic             r4_zero;
    logic [4:0]       r4_n;
    logic [31:0]      r4_f;
    logic             r5_zero;
    logic [4:0]       r5_n;
    logic [POS_W-1:0] r5_pos;
    logic             r6_zero;
    logic [4:0]       r6_n;
    logic [31:0]      r6_hi;
    logic [31:0]      r6_lo;
    logic [31:0]      r6_wt;
    logic             r7_zero;
    logic [4:0]       r7_n;
    logic [31:0]      r7_hi;
    logic [63:0]      r7_prod;
    logic [31:0]      r8_smp;

    logic [38:0]      w_t;
    logic [IDX_W-1:0] w_idx;
    logic [31:0]      w_m;

    assign w_t   = {1'b0, r3_pa, 1'b0} + 39'(r3_pb[63:31]);
    assign w_idx = r5_pos[POS_W-1:32];
    assign w_m   = r7_hi - r7_prod[63:32];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[7:1], i_req.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r1_ax   <= i_req.x[31] ? (32'd0 - i_req.x) : i_req.x;
        r2_x2   <= (64'(r1_ax) * 64'(r1_ax)) >> SQ_SHIFT;
        r3_zero <= (r2_x2 >= BIG_X2);
        r3_pa   <= 37'(r2_x2[36:32]) * 37'(gmi_pkg::LOG2E_Q31);
        r3_pb   <= 64'(r2_x2[31:0]) * 64'(gmi_pkg::LOG2E_Q31);
        r4_zero <= r3_zero || (w_t[38:32] > 7'd31);
        r4_n    <= w_t[36:32];
        r4_f    <= w_t[31:0];
        r5_zero <= r4_zero;
        r5_n    <= r4_n;
        r5_pos  <= POS_W'(r4_f) * POS_W'(EXP_TABLE_ENTRIES);
        r6_zero <= r5_zero;
        r6_n    <= r5_n;
        r6_hi   <= w_tab[w_idx];
        r6_lo   <= w_tab[w_idx + IDX_W'(1)];
        r6_wt   <= r5_pos[31:0];
        r7_zero <= r6_zero;
        r7_n    <= r6_n;
        r7_hi   <= r6_hi;
        r7_prod <= 64'(r6_hi - r6_lo) * 64'(r6_wt);
        r8_smp  <= r7_zero ? 32'd0 : (w_m >> r7_n);
    end

    assign o_rsp.valid = r_v[8];
    assign o_rsp.busy  = |r_v;
    assign o_rsp.value = r8_smp;
endmodule

>>> src/gmi_back.sv
// gmi_back: run sequencer, midpoint generation, accumulation, scaling and result register
// depends on gmi_pkg, gmi_if; drives gmi_div and gmi_eval
module gmi_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  gmi_pkg::t_cmd_slot i_head,
    output logic               o_pop,
    output gmi_pkg::t_div_req  o_div,
    input  gmi_pkg::t_div_rsp  i_div,
    output gmi_pkg::t_smp_req  o_smp,
    input  gmi_pkg::t_smp_rsp  i_smp,
    gmi_result_if.source       o_result
);
    localparam int CW = gmi_pkg::COUNT_W;
    localparam int DW = gmi_pkg::DEN_W;

    gmi_pkg::t_back_state r_state, n_state;

    logic [31:0]     r_lo;
    logic [CW-1:0]   r_n;
    logic [32:0]     r_d;
    logic            r_neg;
    logic [31:0]     r_ad;
    logic [DW-1:0]   r_den;
    logic [32:0]     r_q;
    logic [DW-1:0]   r_rem;
    logic [31:0]     r_dq;
    logic [DW-1:0]   r_dr;
    logic [CW-1:0]   r_k;
    logic [63:0]     r_sum;
    logic [31:0]     r_sq;
    logic [CW-1:0]   r_sr;
    logic [63:0]     r_p1;
    logic [58:0]     r_p2;
    logic [31:0]     r_p3;
    logic [34:0]     r_mag;
    logic            r_div_sent;
    logic            r_out_valid;
    logic [31:0]     r_out_val;

    logic            w_div_state;
    logic [DW:0]     w_rsum;
    logic            w_wrap;
    logic [33:0]     w_x;
    logic [65:0]     w_round;
    logic [31:0]     w_res;
    logic            w_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gmi_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_pop       = 1'b0;
        w_div_state = 1'b0;
        w_load      = 1'b0;
        unique case (r_state)
            gmi_pkg::ST_IDLE: begin
                if (i_head.valid) begin
                    o_pop   = 1'b1;
                    n_state = gmi_pkg::ST_PREP;
                end
            end
            gmi_pkg::ST_PREP: begin
                n_state = (r_n == '0) ? gmi_pkg::ST_FIN : gmi_pkg::ST_DIV_OFS;
            end
            gmi_pkg::ST_DIV_OFS: begin
                w_div_state = 1'b1;
                if (i_div.done) n_state = gmi_pkg::ST_DIV_STEP;
            end
            gmi_pkg::ST_DIV_STEP: begin
                w_div_state = 1'b1;
                if (i_div.done) n_state = gmi_pkg::ST_RUN;
            end
            gmi_pkg::ST_RUN: begin
                if (r_k == r_n - CW'(1)) n_state = gmi_pkg::ST_DRAIN;
            end
            gmi_pkg::ST_DRAIN: begin
                if (!i_smp.busy) n_state = gmi_pkg::ST_DIV_SUM;
            end
            gmi_pkg::ST_DIV_SUM: begin
                w_div_state = 1'b1;
                if (i_div.done) n_state = gmi_pkg::ST_MUL;
            end
            gmi_pkg::ST_MUL: begin
                n_state = gmi_pkg::ST_DIV_FRAC;
            end
            gmi_pkg::ST_DIV_FRAC: begin
                w_div_state = 1'b1;
                if (i_div.done) n_state = gmi_pkg::ST_ROUND;
            end
            gmi_pkg::ST_ROUND: begin
                n_state = gmi_pkg::ST_FIN;
            end
            gmi_pkg::ST_FIN: begin
                if (!r_out_valid || o_result.ready) begin
                    w_load  = 1'b1;
                    n_state = gmi_pkg::ST_IDLE;
                end
            end
            default: n_state = gmi_pkg::ST_IDLE;
        endcase
    end

    // divider operands follow the phase of the run
    always_comb begin
        o_div.start    = w_div_state && !r_div_sent;
        o_div.dividend = r_sum;
        o_div.divisor  = {1'b0, r_n};
        case (r_state)
            gmi_pkg::ST_DIV_OFS: begin
                o_div.dividend = {32'd0, r_ad};
                o_div.divisor  = r_den;
            end
            gmi_pkg::ST_DIV_STEP: begin
                o_div.dividend = {31'd0, r_ad, 1'b0};
                o_div.divisor  = r_den;
            end
            gmi_pkg::ST_DIV_FRAC: o_div.dividend = 64'(r_p2);
            default: ;
        endcase
    end

    // midpoint offset advances by ad/n with its remainder carried against 2n
    assign w_rsum = {1'b0, r_rem} + {1'b0, r_dr};
    assign w_wrap = (w_rsum >= {1'b0, r_den});
    assign w_x    = r_neg ? ({{2{r_lo[31]}}, r_lo} - {1'b0, r_q})
                          : ({{2{r_lo[31]}}, r_lo} + {1'b0, r_q});

    assign o_smp.valid = (r_state == gmi_pkg::ST_RUN);
    assign o_smp.x     = w_x[31:0];

    assign w_round = 66'(r_p1) + 66'(r_p3) + (66'(1) << 30);

    always_comb begin
        if (r_neg) begin
            w_res = (r_mag > 35'h0_8000_0000) ? 32'h8000_0000 : (32'd0 - r_mag[31:0]);
        end else begin
            w_res = (r_mag > 35'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : r_mag[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            gmi_pkg::ST_IDLE: begin
                r_lo <= i_head.cmd.lower;
                r_n  <= i_head.cmd.count;
                r_d  <= {i_head.cmd.upper[31], i_head.cmd.upper}
                      - {i_head.cmd.lower[31], i_head.cmd.lower};
            end
            gmi_pkg::ST_PREP: begin
                r_neg <= r_d[32];
                r_ad  <= r_d[32] ? 32'(33'd0 - r_d) : r_d[31:0];
                r_den <= {r_n, 1'b0};
                r_sum <= '0;
                r_k   <= '0;
                r_mag <= '0;
            end
            gmi_pkg::ST_DIV_OFS: begin
                if (i_div.done) begin
                    r_q   <= i_div.quo[32:0];
                    r_rem <= i_div.rem;
                end
            end
            gmi_pkg::ST_DIV_STEP: begin
                if (i_div.done) begin
                    r_dq <= i_div.quo[31:0];
                    r_dr <= i_div.rem;
                end
            end
            gmi_pkg::ST_RUN: begin
                r_k   <= r_k + CW'(1);
                r_rem <= w_wrap ? DW'(w_rsum - {1'b0, r_den}) : w_rsum[DW-1:0];
                r_q   <= r_q + 33'(r_dq) + 33'(w_wrap);
                if (i_smp.valid) r_sum <= r_sum + 64'(i_smp.value);
            end
            gmi_pkg::ST_DRAIN: begin
                if (i_smp.valid) r_sum <= r_sum + 64'(i_smp.value);
            end
            gmi_pkg::ST_DIV_SUM: begin
                if (i_div.done) begin
                    r_sq <= i_div.quo[31:0];
                    r_sr <= i_div.rem[CW-1:0];
                end
            end
            gmi_pkg::ST_MUL: begin
                r_p1 <= 64'(r_sq) * 64'(r_ad);
                r_p2 <= 59'(r_sr) * 59'(r_ad);
            end
            gmi_pkg::ST_DIV_FRAC: begin
                if (i_div.done) r_p3 <= i_div.quo[31:0];
            end
            gmi_pkg::ST_ROUND: r_mag <= w_round[65:31];
            default: ;
        endcase
        if (w_load) r_out_val <= w_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_sent  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_div.done) begin
                r_div_sent <= 1'b0;
            end else if (o_div.start) begin
                r_div_sent <= 1'b1;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.integral_value = r_out_val;

    a_issue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == gmi_pkg::ST_RUN) |-> (r_k < r_n))
        else $error("sample issued beyond the step count");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == gmi_pkg::ST_RUN) |-> ({1'b0, r_rem} < {1'b0, r_den}))
        else $error("midpoint remainder escaped its divisor");

    a_pipe_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == gmi_pkg::ST_DIV_SUM || r_state == gmi_pkg::ST_IDLE) |-> !i_smp.valid)
        else $error("sample arrived after the sum was taken");

    a_div_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_div_sent && !i_div.done |-> !o_div.start)
        else $error("divider restarted while a division was in flight");
endmodule

>>> src/gaussian_midpoint_integrator_top.sv
// gaussian_midpoint_integrator_top: midpoint-rule integrator of exp(-x*x)
// depends on gmi_pkg, gmi_if, gmi_queue, gmi_front, gmi_div, gmi_eval, gmi_back

// Each request word with go high runs one midpoint-rule integration of exp(-x*x)
// over [lower_limit, upper_limit] (signed q4.28 by default) cut into step_count
// parts, and gives one result word; a request with go low is taken and dropped.
// The front takes requests whenever its two-entry command queue has room, even
// while a result still waits at the output. In a run the evaluator takes one
// midpoint per cycle and has eight stages to drain, and four 64-step divisions
// on one shared divider (start offset, step, sum over step_count, remainder
// scaling) come before and after the samples. Runs are carried out one after
// another. Configuration is written through a plain write port; register 0 is
// lower_limit, 1 upper_limit, 2 step_count.
module gaussian_midpoint_integrator_top #(
    parameter int FRACTION_BITS     = gmi_pkg::FRACTION_BITS_DEF,
    parameter int EXP_TABLE_ENTRIES = gmi_pkg::EXP_TABLE_ENTRIES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [1:0]                  i_cfg_idx,
    input  logic [gmi_pkg::VALUE_W-1:0] i_cfg_data,
    gmi_go_if.sink                      i_go,
    gmi_result_if.source                o_result
);
    // front to queue, queue to back
    gmi_pkg::t_cmd_slot w_push;
    gmi_pkg::t_cmd_slot w_head;
    logic               w_full;
    logic               w_pop;

    // shared divider and sample evaluator
    gmi_pkg::t_div_req  w_div_req;
    gmi_pkg::t_div_rsp  w_div_rsp;
    gmi_pkg::t_smp_req  w_smp_req;
    gmi_pkg::t_smp_rsp  w_smp_rsp;

    gmi_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_go       (i_go),
        .i_q_full   (w_full),
        .o_push     (w_push)
    );

    gmi_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_head  (w_head)
    );

    gmi_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    gmi_eval #(
        .FRACTION_BITS     (FRACTION_BITS),
        .EXP_TABLE_ENTRIES (EXP_TABLE_ENTRIES)
    ) u_eval (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_smp_req),
        .o_rsp   (w_smp_rsp)
    );

    gmi_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (w_head),
        .o_pop    (w_pop),
        .o_div    (w_div_req),
        .i_div    (w_div_rsp),
        .o_smp    (w_smp_req),
        .i_smp    (w_smp_rsp),
        .o_result (o_result)
    );
endmodule

>>> test/gaussian_midpoint_integrator_top_tb.sv
// gaussian_midpoint_integrator_top_tb: self-checking bench for the midpoint integrator
// depends on gmi_pkg, gmi_if and gaussian_midpoint_integrator_top
module gaussian_midpoint_integrator_top_tb;

    localparam int          TABLE_N     = gmi_pkg::EXP_TABLE_ENTRIES_DEF;
    localparam int          VAL_W       = gmi_pkg::VALUE_W;
    localparam int          CNT_W       = gmi_pkg::COUNT_W;
    localparam int          HOLD_CYCLES = 3000;
    localparam int          SETTLE      = 400;
    localparam longint      LIMIT       = 2000000;
    localparam bit [63:0]   LN2_C       = 64'd2977044472;
    localparam bit [63:0]   LOG2E_C     = 64'd3098164009;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [1:0]           i_cfg_idx;
    logic [VAL_W-1:0]     i_cfg_data;

    gmi_go_if     go_ch();
    gmi_result_if res_ch();

    gaussian_midpoint_integrator_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_go       (go_ch),
        .o_result   (res_ch)
    );

    // bench copy of the configuration registers
    logic [VAL_W-1:0]   cfg_lower;
    logic [VAL_W-1:0]   cfg_upper;
    logic [CNT_W-1:0]   cfg_count;

    bit [31:0]          exp_rom [0:TABLE_N];
    logic               go_pending [$];
    logic [31:0]        integral_expected [$];

    int     n_errors;
    int     n_results;
    int     n_words;
    int     n_settings;
    longint n_cycles;
    bit     no_idle;
    bit     hold_arm;
    bit     hold_done;
    int     hold_cnt;

    // 2^-z for a q32 fraction, q31, by the exp(-z ln2) series
    function automatic bit [31:0] pow2_frac(bit [63:0] z);
        bit [63:0] u;
        bit [63:0] term;
        bit [63:0] pos;
        bit [63:0] negs;
        bit [63:0] r;
        u    = (z * LN2_C) >> 32;
        term = 64'd1 << 32;
        pos  = term;
        negs = 0;
        for (int k = 1; k <= 24; k++) begin
            term = ((term * u) >> 32) / 64'(k);
            if (k % 2 == 1) negs += term;
            else pos += term;
        end
        r = ((pos - negs) + 64'd1) >> 1;
        return r[31:0];
    endfunction

    // q1.31 value of exp(-x*x) for a q4.28 abscissa
    function automatic bit [63:0] gauss_at(longint x);
        bit [63:0] ax;
        bit [63:0] x2;
        bit [63:0] t;
        bit [63:0] f;
        bit [63:0] p;
        bit [63:0] hi;
        bit [63:0] lo;
        bit [63:0] m;
        bit [31:0] sh;
        ax = (x < 0) ? -x : x;
        x2 = (ax * ax) >> (2 * gmi_pkg::FRACTION_BITS_DEF - 32);
        if (x2 >= (64'd22 << 32)) return 0;
        t  = (((x2 >> 32) * LOG2E_C) << 1) + (((x2 & 64'hFFFF_FFFF) * LOG2E_C) >> 31);
        sh = t[63:32];
        if (sh > 31) return 0;
        f  = t & 64'hFFFF_FFFF;
        p  = f * 64'(TABLE_N);
        hi = exp_rom[p[63:32]];
        lo = exp_rom[p[63:32] + 1];
        m  = hi - (((hi - lo) * (p & 64'hFFFF_FFFF)) >> 32);
        return m >> sh;
    endfunction

    // midpoint-rule integral over the current bench configuration
    function automatic logic [31:0] integrate_gauss(logic [31:0] lo32, logic [31:0] up32,
                                                    logic [CNT_W-1:0] cnt);
        longint    lo;
        longint    d;
        bit        neg;
        bit [63:0] ad;
        bit [63:0] n;
        bit [63:0] den;
        bit [63:0] q;
        bit [63:0] r;
        bit [63:0] dq;
        bit [63:0] dr;
        bit [63:0] acc;
        bit [63:0] mag;
        bit [63:0] res;
        lo  = longint'($signed(lo32));
        d   = longint'($signed(up32)) - lo;
        neg = d < 0;
        ad  = neg ? -d : d;
        n   = 64'(cnt);
        if (n == 0) return 32'd0;
        den = 2 * n;
        q   = ad / den;
        r   = ad % den;
        dq  = (2 * ad) / den;
        dr  = (2 * ad) % den;
        acc = 0;
        for (bit [63:0] k = 0; k < n; k++) begin
            acc += gauss_at(neg ? lo - longint'(q) : lo + longint'(q));
            q += dq;
            r += dr;
            if (r >= den) begin
                r -= den;
                q++;
            end
        end
        mag = ((acc / n) * ad + ((acc % n) * ad) / n + (64'd1 << 30)) >> 31;
        if (neg) res = (mag > 64'h8000_0000) ? 64'hFFFF_FFFF_8000_0000 : -mag;
        else     res = (mag > 64'h7FFF_FFFF) ? 64'h7FFF_FFFF : mag;
        return res[31:0];
    endfunction

    // clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // cycle limit, ends a hung run
    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles > LIMIT) begin
            $display("timeout after %0d cycles", n_cycles);
            $display("gaussian_midpoint_integrator_top_tb NOT OK");
            $finish;
        end
    end

    // request driver: offers the oldest pending word, predicts on acceptance
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            go_ch.valid <= 1'b0;
            go_ch.go    <= 1'b0;
        end else begin
            if (go_ch.valid && go_ch.ready) begin
                if (go_ch.go)
                    integral_expected.push_back(integrate_gauss(cfg_lower, cfg_upper, cfg_count));
                n_words <= n_words + 1;
                void'(go_pending.pop_front());
            end
            // valid stays up until the word is taken
            if (!go_ch.valid || go_ch.ready) begin
                if (go_pending.size() > 0 && (no_idle || $urandom_range(0, 99) >= 11)) begin
                    go_ch.valid <= 1'b1;
                    go_ch.go    <= go_pending[0];
                end else begin
                    go_ch.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor with random back-pressure and one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                if (integral_expected.size() == 0) begin
                    $display("%0t: unexpected result, actual %h", $time,
                             res_ch.integral_value);
                    n_errors <= n_errors + 1;
                end else begin
                    if (res_ch.integral_value !== integral_expected[0]) begin
                        $display("%0t: integral_value mismatch, expected %h actual %h",
                                 $time, integral_expected[0], res_ch.integral_value);
                        n_errors <= n_errors + 1;
                    end
                    void'(integral_expected.pop_front());
                end
                n_results <= n_results + 1;
            end
            if (hold_arm && !hold_done) begin
                // receiver stalls while the sender keeps offering words
                hold_cnt <= hold_cnt + 1;
                if (hold_cnt >= HOLD_CYCLES) hold_done <= 1'b1;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= no_idle || ($urandom_range(0, 99) >= 11);
            end
        end
    end

    // register write, only while the block is idle
    task automatic write_reg(gmi_pkg::t_cfg_reg idx, logic [31:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        case (idx)
            gmi_pkg::CFG_LOWER: cfg_lower = val;
            gmi_pkg::CFG_UPPER: cfg_upper = val;
            default:            cfg_count = val[CNT_W-1:0];
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_interval(logic [31:0] lo, logic [31:0] up, logic [CNT_W-1:0] cnt);
        write_reg(gmi_pkg::CFG_LOWER, lo);
        write_reg(gmi_pkg::CFG_UPPER, up);
        write_reg(gmi_pkg::CFG_COUNT, 32'(cnt));
        n_settings++;
    endtask

    // wait for every word to go in and every result to come back, then let
    // dropped go-low words clear the pipe
    task automatic drain();
        while (go_pending.size() != 0 || go_ch.valid || integral_expected.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic run_phase(logic [31:0] lo, logic [31:0] up, logic [CNT_W-1:0] cnt,
                             int words, int pct_low);
        set_interval(lo, up, cnt);
        repeat (words) go_pending.push_back($urandom_range(0, 99) >= pct_low);
        drain();
    endtask

    // random interval: mostly inside +-4, sometimes anywhere
    function automatic logic [31:0] rand_limit();
        if ($urandom_range(0, 3) == 0) return $urandom;
        return 32'($signed($urandom_range(0, 32'h8000_0000)) - 32'sh4000_0000);
    endfunction

    function automatic logic [CNT_W-1:0] rand_count();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick == 0) return 0;
        if (pick == 1) return CNT_W'($urandom_range(256, 1024));
        return CNT_W'($urandom_range(1, 64));
    endfunction

    initial begin
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = gmi_pkg::CFG_LOWER;
        i_cfg_data = '0;
        go_ch.valid  = 1'b0;
        go_ch.go     = 1'b0;
        res_ch.ready = 1'b0;
        n_errors = 0; n_results = 0; n_words = 0; n_settings = 0; n_cycles = 0;
        no_idle = 1'b0; hold_arm = 1'b0; hold_done = 1'b0; hold_cnt = 0;
        cfg_lower = gmi_pkg::RESET_LOWER;
        cfg_upper = gmi_pkg::RESET_UPPER;
        cfg_count = gmi_pkg::RESET_COUNT;
        for (int i = 0; i <= TABLE_N; i++)
            exp_rom[i] = pow2_frac((64'(i) << 32) / 64'(TABLE_N));
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // reset limits with a short count, go low words dropped
        write_reg(gmi_pkg::CFG_COUNT, 32'd8);
        go_pending.push_back(1'b1);
        go_pending.push_back(1'b0);
        go_pending.push_back(1'b1);
        go_pending.push_back(1'b0);
        drain();
        // zero step count gives zero
        run_phase(gmi_pkg::RESET_LOWER, gmi_pkg::RESET_UPPER, 0, 2, 0);
        // widest interval in one step saturates high, reversed saturates low
        run_phase(32'h8000_0000, 32'h7FFF_FFFF, 1, 2, 0);
        run_phase(32'h7FFF_FFFF, 32'h8000_0000, 1, 2, 0);
        // far tail, every sample flushed to zero
        run_phase(32'h5000_0000, 32'h7FFF_FFFF, 16, 2, 0);
        run_phase(32'hB000_0000, 32'h8000_0000, 16, 2, 0);
        // empty interval
        run_phase(32'h0000_0000, 32'h0000_0000, 5, 2, 0);
        // a count of 2^26 written then replaced, the run itself would take too long
        write_reg(gmi_pkg::CFG_COUNT, 32'd67108864);
        run_phase(gmi_pkg::RESET_LOWER, gmi_pkg::RESET_UPPER, 4096, 1, 0);
        run_phase(32'hFFFF_FFFF, 32'h0000_0001, 3, 2, 0);

        // long receiver hold-off: queue fills and the input stalls
        hold_arm = 1'b1;
        run_phase(gmi_pkg::RESET_LOWER, gmi_pkg::RESET_UPPER, 2, 8, 0);

        // stretch without idling on either side
        no_idle = 1'b1;
        run_phase(rand_limit(), rand_limit(), rand_count(), 10, 15);
        no_idle = 1'b0;

        for (int p = 0; p < 7; p++)
            run_phase(rand_limit(), rand_limit(), rand_count(), 10, 15);

        drain();
        if (integral_expected.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, integral_expected.size());
            n_errors++;
        end
        $display("covered %0d request words and %0d results over %0d interval settings,",
                 n_words, n_results, n_settings);
        $display("including saturation, zero count, empty and reversed intervals and stalls");
        if (n_errors == 0) begin
            $display("gaussian_midpoint_integrator_top_tb OK");
        end else begin
            $display("gaussian_midpoint_integrator_top_tb NOT OK");
        end
        $finish;
    end

endmodule
